// ===== sv/bessel_poly_recurrence_eval_top_defines.svh =====
// ----------------------------------------------------------------------------
// Bessel polynomial evaluator: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BESSEL_POLY_RECURRENCE_EVAL_TOP_DEFINES_SVH
`define BESSEL_POLY_RECURRENCE_EVAL_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPRE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpre_pkg.sv =====
// ----------------------------------------------------------------------------
// Bessel polynomial evaluator: package
// Widths, sequencer types, multiply-accumulate control and saturation.
// ----------------------------------------------------------------------------
package bpre_pkg;

  // Value and operand widths.
  localparam int VAL_W  = 64;
  localparam int HALF_W = 32;
  localparam int X_W    = 24;
  localparam int B_W    = 33;
  localparam int PROD_W = 2 * B_W;
  localparam int ACC_W  = 100;
  localparam int Q_SHIFT = 16;

  localparam logic signed [VAL_W-1:0] ONE_Q16  = 64'sd65536;
  localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(32768);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_SAT,
    ST_RND,
    ST_ADD
  } state_t;

  // Which product the multiply phase is forming.
  typedef enum logic [1:0] {
    PH_X2,
    PH_SCALE,
    PH_CMUL
  } phase_t;

  // One partial product issued to the shared multiplier.
  typedef struct packed {
    logic valid;
    logic hi;      // upper half of the wide operand, weighted by 2^32
    logic dst_im;  // accumulate into the imaginary accumulator
    logic neg;     // subtract instead of add
    logic clr;     // first term of the accumulator: overwrite
  } mac_op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    ovf;
  } sat_t;

  // Saturate a wide signed value to the 64-bit range.
  function automatic sat_t sat64(input logic signed [ACC_W-1:0] v);
    sat_t r;
    logic [ACC_W-VAL_W:0] hi;
    hi = v[ACC_W-1:VAL_W-1];
    if ((&hi) || !(|hi)) begin
      r.val = v[VAL_W-1:0];
      r.ovf = 1'b0;
    end else begin
      r.val = v[ACC_W-1] ? VAL_MIN : VAL_MAX;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/bpre_mac.sv =====
// ----------------------------------------------------------------------------
// Bessel polynomial evaluator: shared multiply-accumulate unit
// One 33x33 signed multiplier with a product register, feeding two
// accumulators that collect the real and imaginary sums.
// ----------------------------------------------------------------------------
module bpre_mac
  import bpre_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  input  logic signed [VAL_W-1:0] a_val,
  input  logic signed [B_W-1:0]   b_val,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im
);

  logic signed [B_W-1:0]    a_part;
  logic signed [PROD_W-1:0] prod;
  mac_op_t                  tag;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  // Pick one half of the wide operand: the low half unsigned, the high half signed.
  always_comb begin
    if (op.hi) begin
      a_part = $signed({a_val[VAL_W-1], a_val[VAL_W-1:HALF_W]});
    end else begin
      a_part = $signed({1'b0, a_val[HALF_W-1:0]});
    end
  end

  // Multiplier stage: register the product and its control.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= op;
    end
    prod <= a_part * b_val;
  end

  // Weight the product and apply the sign of the term.
  always_comb begin
    addend = ACC_W'(prod);
    if (tag.hi) begin
      addend = addend <<< HALF_W;
    end
    term = tag.neg ? -addend : addend;
    base = tag.dst_im ? acc_im : acc_re;
    if (tag.clr) begin
      base = '0;
    end
  end

  // Accumulator stage.
  always_ff @(posedge clk) begin
    if (tag.valid) begin
      if (tag.dst_im) begin
        acc_im <= base + term;
      end else begin
        acc_re <= base + term;
      end
    end
  end

endmodule

// ===== sv/bessel_poly_recurrence_eval_top.sv =====
// ----------------------------------------------------------------------------
// Bessel polynomial evaluator: top level
// Evaluates y_n(x) or the reversed theta_n(x) for complex Q7.16 x, Q47.16 out.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low. The result
// appears on val_re, val_im and overflow for exactly one cycle, marked by done;
// the receiver cannot stall it, so capture it on that cycle. Orders zero and one
// give done in the next cycle with busy never raised. For an order n of two or
// more (clamped to MAX_ORDER) busy stays high through every step, and done
// follows in the cycle busy falls, in which a new command may already be taken.
// The run time is set by the single 33x33 multiplier: x*x costs 8 partial
// products, and each recurrence step costs 4 for the scaling by 2k-1 and 8
// for the complex product, plus the drain, round, saturate and add states.
`include "bessel_poly_recurrence_eval_top_defines.svh"

module bessel_poly_recurrence_eval_top
  import bpre_pkg::*;
#(
  parameter int MAX_ORDER = 15
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode,
  input  logic [3:0]              order,
  input  logic signed [X_W-1:0]   x_re,
  input  logic signed [X_W-1:0]   x_im,
  output logic                    done,
  output logic signed [VAL_W-1:0] val_re,
  output logic signed [VAL_W-1:0] val_im,
  output logic                    overflow
);

  localparam int K_W = $clog2(MAX_ORDER + 1);
  localparam int N_W = (K_W > 4) ? K_W : 4;
  localparam int C_W = N_W + 1;

  // Terms of a complex product (a_re + j a_im) * (b_re + j b_im).
  localparam logic [1:0] TERM_RR = 2'd0;
  localparam logic [1:0] TERM_II = 2'd1;
  localparam logic [1:0] TERM_IR = 2'd2;
  localparam logic [1:0] TERM_RI = 2'd3;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [2:0] uop, uop_next;

  // Command and recurrence registers.
  logic                    md;
  logic [N_W-1:0]          n_eff;
  logic [N_W-1:0]          step;
  logic signed [X_W-1:0]   xr, xi;
  logic signed [B_W-1:0]   x2_re, x2_im;
  logic signed [VAL_W-1:0] p0_re, p0_im, p1_re, p1_im;
  logic signed [VAL_W-1:0] s_re, s_im, t_re, t_im;
  logic                    ovf;

  logic [N_W-1:0]          ord_ext;
  logic [N_W-1:0]          ord_clamp;
  logic [C_W-1:0]          coef;
  logic                    last_uop;
  mac_op_t                 op;
  logic                    a_sel_im, b_sel_im;
  logic signed [VAL_W-1:0] a_re, a_im, a_val;
  logic signed [B_W-1:0]   b_re, b_im, b_val;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [ACC_W-1:0] rnd_sum_re, rnd_sum_im;
  sat_t                    rnd_re, rnd_im, scl_re, scl_im, add_re, add_im;
  logic signed [VAL_W:0]   sum_re, sum_im;

  assign busy = (state != ST_IDLE);

  // Clamp the requested order and form the scale factor 2k-1.
  assign ord_ext   = N_W'(order);
  assign ord_clamp = (ord_ext > N_W'(MAX_ORDER)) ? N_W'(MAX_ORDER) : ord_ext;
  assign coef      = {step, 1'b0} - C_W'(1);
  assign last_uop  = (phase == PH_SCALE) ? (uop == 3'd3) : (uop == 3'd7);

  // Decode the current partial product.
  always_comb begin
    op.valid = (state == ST_MUL);
    op.hi    = uop[0];
    op.neg   = 1'b0;
    a_sel_im = 1'b0;
    b_sel_im = 1'b0;
    op.dst_im = 1'b0;
    op.clr   = 1'b0;
    if (phase == PH_SCALE) begin
      a_sel_im  = uop[1];
      op.dst_im = uop[1];
      op.clr    = !uop[0];
    end else begin
      unique case (uop[2:1])
        TERM_RR: begin
          op.clr = !uop[0];
        end
        TERM_II: begin
          a_sel_im = 1'b1;
          b_sel_im = 1'b1;
          op.neg   = 1'b1;
        end
        TERM_IR: begin
          a_sel_im  = 1'b1;
          op.dst_im = 1'b1;
          op.clr    = !uop[0];
        end
        TERM_RI: begin
          b_sel_im  = 1'b1;
          op.dst_im = 1'b1;
        end
        default: begin
          op.clr = 1'b0;
        end
      endcase
    end
  end

  // Operand routing for each phase.
  always_comb begin
    unique case (phase)
      PH_X2: begin
        a_re = VAL_W'(xr);
        a_im = VAL_W'(xi);
        b_re = B_W'(xr);
        b_im = B_W'(xi);
      end
      PH_SCALE: begin
        a_re = p1_re;
        a_im = p1_im;
        b_re = $signed(B_W'(coef));
        b_im = $signed(B_W'(coef));
      end
      default: begin
        if (md) begin
          a_re = p0_re;
          a_im = p0_im;
          b_re = x2_re;
          b_im = x2_im;
        end else begin
          a_re = s_re;
          a_im = s_im;
          b_re = B_W'(xr);
          b_im = B_W'(xi);
        end
      end
    endcase
    a_val = a_sel_im ? a_im : a_re;
    b_val = b_sel_im ? b_im : b_re;
  end

  bpre_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .a_val  (a_val),
    .b_val  (b_val),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // Round the accumulators to Q.16, or saturate them as integer scaled values.
  always_comb begin
    rnd_sum_re = (acc_re + RND_HALF) >>> Q_SHIFT;
    rnd_sum_im = (acc_im + RND_HALF) >>> Q_SHIFT;
    rnd_re     = sat64(rnd_sum_re);
    rnd_im     = sat64(rnd_sum_im);
    scl_re     = sat64(acc_re);
    scl_im     = sat64(acc_im);
  end

  // Recurrence sum for the next polynomial value.
  always_comb begin
    if (md) begin
      sum_re = {s_re[VAL_W-1], s_re} + {t_re[VAL_W-1], t_re};
      sum_im = {s_im[VAL_W-1], s_im} + {t_im[VAL_W-1], t_im};
    end else begin
      sum_re = {p0_re[VAL_W-1], p0_re} + {t_re[VAL_W-1], t_re};
      sum_im = {p0_im[VAL_W-1], p0_im} + {t_im[VAL_W-1], t_im};
    end
    add_re = sat64(ACC_W'(sum_re));
    add_im = sat64(ACC_W'(sum_im));
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_X2;
      uop   <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      uop   <= uop_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    phase_next = phase;
    uop_next   = uop;
    unique case (state)
      ST_IDLE: begin
        if (start && (ord_clamp >= N_W'(2))) begin
          state_next = ST_MUL;
          phase_next = PH_X2;
          uop_next   = '0;
        end
      end
      ST_MUL: begin
        uop_next = uop + 3'd1;
        if (last_uop) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = (phase == PH_SCALE) ? ST_SAT : ST_RND;
      end
      ST_SAT: begin
        state_next = ST_MUL;
        phase_next = PH_CMUL;
        uop_next   = '0;
      end
      ST_RND: begin
        if (phase == PH_X2) begin
          state_next = ST_MUL;
          phase_next = PH_SCALE;
          uop_next   = '0;
        end else begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        uop_next = '0;
        if (step == n_eff) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
          phase_next = PH_SCALE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_IDLE) && start && (ord_clamp < N_W'(2))) ||
              ((state == ST_ADD) && (step == n_eff));
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          md       <= mode;
          n_eff    <= ord_clamp;
          step     <= N_W'(2);
          xr       <= x_re;
          xi       <= x_im;
          p0_re    <= ONE_Q16;
          p0_im    <= '0;
          p1_re    <= VAL_W'(x_re) + ONE_Q16;
          p1_im    <= VAL_W'(x_im);
          ovf      <= 1'b0;
          overflow <= 1'b0;
          if (ord_clamp == '0) begin
            val_re <= ONE_Q16;
            val_im <= '0;
          end else begin
            val_re <= VAL_W'(x_re) + ONE_Q16;
            val_im <= VAL_W'(x_im);
          end
        end
      end
      ST_SAT: begin
        s_re <= scl_re.val;
        s_im <= scl_im.val;
        ovf  <= ovf | scl_re.ovf | scl_im.ovf;
      end
      ST_RND: begin
        if (phase == PH_X2) begin
          x2_re <= rnd_re.val[B_W-1:0];
          x2_im <= rnd_im.val[B_W-1:0];
        end else begin
          t_re <= rnd_re.val;
          t_im <= rnd_im.val;
          ovf  <= ovf | rnd_re.ovf | rnd_im.ovf;
        end
      end
      ST_ADD: begin
        p0_re    <= p1_re;
        p0_im    <= p1_im;
        p1_re    <= add_re.val;
        p1_im    <= add_im.val;
        ovf      <= ovf | add_re.ovf | add_im.ovf;
        step     <= step + N_W'(1);
        val_re   <= add_re.val;
        val_im   <= add_im.val;
        overflow <= ovf | add_re.ovf | add_im.ovf;
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // A result is only presented once the sequencer is free again.
  `BPRE_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  // An accepted command either starts the sequencer or returns at once.
  `BPRE_ASSERT_NEXT(a_start_acts, start && !busy, busy || done, "command dropped")
  // The scaling phase issues only four partial products.
  `BPRE_ASSERT_SAME(a_scale_len, (state == ST_MUL) && (phase == PH_SCALE), !uop[2],
                    "scaling phase overran")
  // Recurrence steps stay within the clamped order.
  `BPRE_ASSERT_SAME(a_step_range, state == ST_ADD,
                    (step >= N_W'(2)) && (step <= n_eff), "step out of range")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Bessel polynomial evaluator: testbench
// Drives order, mode and complex argument commands through the start/busy
// handshake. Each accepted command is run through a local fixed-point model
// of the recurrence, and every done strobe is checked against the oldest
// predicted value. The stimulus is a directed set of edge cases followed by
// random commands, with random idle bursts and periodic full drain pauses.
// ----------------------------------------------------------------------------
module testbench
  import bpre_pkg::*;
();

  localparam int MAX_ORDER   = 15;
  localparam int RANDOM_CMDS = 1380;
  localparam int TAIL_CMDS   = 80;
  localparam int SETTLE_CYC  = 300;

  // Mode codes.
  localparam logic MODE_Y     = 1'b0;
  localparam logic MODE_THETA = 1'b1;

  // Argument values of interest, Q7.16.
  localparam logic signed [X_W-1:0] X_MAX     = 24'sh7FFFFF;
  localparam logic signed [X_W-1:0] X_MIN     = 24'sh800000;
  localparam logic signed [X_W-1:0] X_ZERO    = 24'sd0;
  localparam logic signed [X_W-1:0] X_ONE     = 24'sd65536;
  localparam logic signed [X_W-1:0] X_NEG_ONE = -24'sd65536;

  typedef struct {
    logic                  mode;
    logic [3:0]            order;
    logic signed [X_W-1:0] x_re;
    logic signed [X_W-1:0] x_im;
    bit                    drain_first;
  } bessel_cmd_t;

  typedef struct {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic                    ovf;
  } bessel_val_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    mode = 1'b0;
  logic [3:0]              order = 4'd0;
  logic signed [X_W-1:0]   x_re = '0;
  logic signed [X_W-1:0]   x_im = '0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] val_re;
  logic signed [VAL_W-1:0] val_im;
  logic                    overflow;

  bessel_cmd_t cmd_queue[$];
  bessel_val_t awaiting_vals[$];
  bessel_cmd_t cur_cmd;
  int          total_cmds = 0;
  int          accepted_count = 0;
  int          gap_left = 0;
  int          error_count = 0;

  bessel_poly_recurrence_eval_top #(
    .MAX_ORDER(MAX_ORDER)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .order(order),
    .x_re(x_re),
    .x_im(x_im),
    .done(done),
    .val_re(val_re),
    .val_im(val_im),
    .overflow(overflow)
  );

  always #1 clk = ~clk;

  // Full-width signed product of two 64-bit values.
  function automatic logic signed [127:0] wmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = 128'(a);
    wb = 128'(b);
    return wa * wb;
  endfunction

  // Round a Q.32 product to Q.16, ties toward plus infinity.
  function automatic logic signed [127:0] round_q16(input logic signed [127:0] v);
    return (v + 128'sd32768) >>> Q_SHIFT;
  endfunction

  // Clip to the signed 64-bit range and note any saturation.
  function automatic logic signed [63:0] clip64(input logic signed [127:0] v,
                                                inout logic ovf);
    if (v[127:63] == {65{v[63]}}) return v[63:0];
    ovf = 1'b1;
    return v[127] ? VAL_MIN : VAL_MAX;
  endfunction

  // Complex Q.16 product with a single rounding per part.
  function automatic void cmul_q16(input logic signed [63:0] ar,
                                   input logic signed [63:0] ai,
                                   input logic signed [63:0] br,
                                   input logic signed [63:0] bi,
                                   output logic signed [63:0] rr,
                                   output logic signed [63:0] ri,
                                   inout logic ovf);
    rr = clip64(round_q16(wmul(ar, br) - wmul(ai, bi)), ovf);
    ri = clip64(round_q16(wmul(ar, bi) + wmul(ai, br)), ovf);
  endfunction

  // Polynomial value for one command, by forward iteration from p0 and p1.
  function automatic bessel_val_t predict_value(input bessel_cmd_t c);
    bessel_val_t r;
    logic signed [63:0] xr, xi, pr0, pi0, pr1, pi1, sqr, sqi;
    logic signed [63:0] sr, si, tr, ti, nr, ni, coef;
    logic ovf;
    int n;
    xr = 64'(c.x_re);
    xi = 64'(c.x_im);
    pr0 = ONE_Q16;
    pi0 = 64'sd0;
    pr1 = xr + ONE_Q16;
    pi1 = xi;
    ovf = 1'b0;
    n = int'(c.order);
    if (n > MAX_ORDER) n = MAX_ORDER;
    cmul_q16(xr, xi, xr, xi, sqr, sqi, ovf);
    for (int k = 2; k <= n; k++) begin
      coef = 64'(2 * k - 1);
      sr = clip64(wmul(pr1, coef), ovf);
      si = clip64(wmul(pi1, coef), ovf);
      if (c.mode == MODE_Y) begin
        cmul_q16(xr, xi, sr, si, tr, ti, ovf);
        nr = clip64(wmul(tr, 64'sd1) + wmul(pr0, 64'sd1), ovf);
        ni = clip64(wmul(ti, 64'sd1) + wmul(pi0, 64'sd1), ovf);
      end else begin
        cmul_q16(sqr, sqi, pr0, pi0, tr, ti, ovf);
        nr = clip64(wmul(sr, 64'sd1) + wmul(tr, 64'sd1), ovf);
        ni = clip64(wmul(si, 64'sd1) + wmul(ti, 64'sd1), ovf);
      end
      pr0 = pr1;
      pi0 = pi1;
      pr1 = nr;
      pi1 = ni;
    end
    if (n == 0) begin
      r.re = pr0;
      r.im = pi0;
    end else begin
      r.re = pr1;
      r.im = pi1;
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic add_cmd(input logic m, input logic [3:0] n,
                         input logic signed [X_W-1:0] re,
                         input logic signed [X_W-1:0] im, input bit drain);
    bessel_cmd_t c;
    c.mode = m;
    c.order = n;
    c.x_re = re;
    c.x_im = im;
    c.drain_first = drain;
    cmd_queue.push_back(c);
  endtask

  // Random argument part: mostly moderate values, some full range and edges.
  function automatic logic signed [X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 24'($urandom_range(0, 524288)) - 24'sd262144;
      4, 5, 6:    return 24'($urandom());
      7: begin
        case ($urandom_range(0, 4))
          0:       return X_MAX;
          1:       return X_MIN;
          2:       return X_ZERO;
          3:       return X_ONE;
          default: return X_NEG_ONE;
        endcase
      end
      8:       return ($urandom_range(0, 1) ? X_ONE : X_NEG_ONE)
                      + 24'($urandom_range(0, 4095)) - 24'sd2048;
      default: return 24'($urandom_range(0, 511)) - 24'sd256;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: hold a command until its transfer, then idle or present the next.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaiting_vals.push_back(predict_value(cur_cmd));
        accepted_count++;
      end
      if (start && busy) begin
        // The block is still working; the command stays on the ports.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        mode <= 1'($urandom());
        order <= 4'($urandom());
        x_re <= 24'($urandom());
        x_im <= 24'($urandom());
      end else if (cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_queue[0].drain_first && awaiting_vals.size() != 0) begin
        // Hold off until every outstanding value has come back.
        start <= 1'b0;
      end else if (accepted_count < total_cmds - TAIL_CMDS &&
                   (accepted_count % 250) < 190 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 16) - 1;
        start <= 1'b0;
        mode <= 1'($urandom());
        order <= 4'($urandom());
        x_re <= 24'($urandom());
        x_im <= 24'($urandom());
      end else begin
        cur_cmd = cmd_queue.pop_front();
        mode <= cur_cmd.mode;
        order <= cur_cmd.order;
        x_re <= cur_cmd.x_re;
        x_im <= cur_cmd.x_im;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every done strobe is one result transfer.
  always @(posedge clk) begin : check_results
    bessel_val_t want;
    if (!rst && done) begin
      if (awaiting_vals.size() == 0) begin
        report_mismatch("result with nothing outstanding, val_re", val_re, '0);
      end else begin
        want = awaiting_vals.pop_front();
        if (val_re !== want.re) report_mismatch("val_re", val_re, want.re);
        if (val_im !== want.im) report_mismatch("val_im", val_im, want.im);
        if (overflow !== want.ovf) report_mismatch("overflow", 64'(overflow), 64'(want.ovf));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Order zero and order one, at the argument extremes.
    add_cmd(MODE_Y, 4'd0, X_ZERO, X_ZERO, 1'b0);
    add_cmd(MODE_THETA, 4'd0, X_MAX, X_MIN, 1'b0);
    add_cmd(MODE_Y, 4'd1, X_MAX, X_MAX, 1'b0);
    add_cmd(MODE_THETA, 4'd1, X_MIN, X_MIN, 1'b0);
    add_cmd(MODE_Y, 4'd1, X_NEG_ONE, X_ZERO, 1'b0);
    // First recurrence step.
    add_cmd(MODE_Y, 4'd2, X_ONE, X_ZERO, 1'b0);
    add_cmd(MODE_THETA, 4'd2, X_ZERO, X_ONE, 1'b0);
    // Largest order with huge arguments saturates.
    add_cmd(MODE_Y, 4'd15, X_MAX, X_MAX, 1'b0);
    add_cmd(MODE_THETA, 4'd15, X_MAX, X_MAX, 1'b0);
    add_cmd(MODE_Y, 4'd15, X_MIN, X_MIN, 1'b0);
    add_cmd(MODE_THETA, 4'd15, X_MIN, X_MIN, 1'b0);
    add_cmd(MODE_Y, 4'd15, X_ZERO, X_MIN, 1'b0);
    add_cmd(MODE_THETA, 4'd15, X_MIN, X_ZERO, 1'b0);
    add_cmd(MODE_Y, 4'd9, X_MAX, X_ZERO, 1'b0);
    // Largest order with unit and zero arguments.
    add_cmd(MODE_Y, 4'd15, X_ONE, X_ZERO, 1'b0);
    add_cmd(MODE_THETA, 4'd15, X_ONE, X_ZERO, 1'b0);
    add_cmd(MODE_Y, 4'd15, X_ZERO, X_ZERO, 1'b0);
    add_cmd(MODE_THETA, 4'd15, X_NEG_ONE, X_ZERO, 1'b0);
    // Rounding ties in x*x, positive and negative, and the smallest steps.
    add_cmd(MODE_Y, 4'd3, 24'sd128, 24'sd128, 1'b0);
    add_cmd(MODE_THETA, 4'd3, 24'sd128, -24'sd128, 1'b0);
    add_cmd(MODE_Y, 4'd7, 24'sd1, -24'sd1, 1'b0);
    add_cmd(MODE_THETA, 4'd7, -24'sd1, 24'sd1, 1'b0);
    // The order port cannot exceed MAX_ORDER here, so clamping is never hit.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      add_cmd(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_x(), rand_x(),
              (i % 350) == 0);
    end
    total_cmds = cmd_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_cmds || awaiting_vals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
